### rtl/lcd_speed_time_frame_encoder_core_assert.svh
// Assertion macros shared by the LCD frame encoder RTL.
`ifndef LCD_SPEED_TIME_FRAME_ENCODER_CORE_ASSERT_SVH
`define LCD_SPEED_TIME_FRAME_ENCODER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSTFE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lstfe same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LSTFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lstfe next-cycle check failed");

`endif

### rtl/lstfe_pkg.sv
// Package for the LCD frame encoder: field widths, segment font and constant dividers.
package lstfe_pkg;

    localparam int SPEED_W = 12;
    localparam int SHOWN_W = 13;
    localparam int SEC_W   = 16;

    localparam logic [12:0] REMAP_KNEE = 13'd2200;
    localparam logic [12:0] TIME_MAX   = 13'd5999;
    localparam logic [7:0]  DASH_SEG   = 8'h20;

    localparam logic [1:0] EDIT_NONE  = 2'd0;
    localparam logic [1:0] EDIT_SPEED = 2'd1;
    localparam logic [1:0] EDIT_TIME  = 2'd2;
    localparam logic [1:0] EDIT_SPARE = 2'd3;

    localparam logic [1:0] RAMP_IDLE = 2'd0;
    localparam logic [1:0] RAMP_RISE = 2'd1;
    localparam logic [1:0] RAMP_FALL = 2'd2;
    localparam logic [1:0] RAMP_HOLD = 2'd3;

    typedef struct packed {
        logic               icon_blank;
        logic               time_blank;
        logic               speed_blank;
        logic               jog_mode;
        logic               time_hidden;
        logic [SEC_W-1:0]   elapsed_seconds;
        logic [SEC_W-1:0]   set_seconds;
        logic [SPEED_W-1:0] measured_speed;
        logic [SPEED_W-1:0] target_speed;
        logic [SPEED_W-1:0] user_speed;
        logic [1:0]         edit_mode;
        logic               running;
    } t_in_item;

    typedef struct packed {
        logic       minutes_unit;
        logic [7:0] time_low_lower;
        logic [7:0] time_low_upper;
        logic [7:0] time_high_segments;
        logic [7:0] ones_segments;
        logic [7:0] tens_segments;
        logic [7:0] hundreds_segments;
    } t_out_item;

    function automatic logic [7:0] font(input logic [3:0] d);
        logic [7:0] seg;
        case (d)
            4'd0: seg = 8'h5F;
            4'd1: seg = 8'h06;
            4'd2: seg = 8'h3D;
            4'd3: seg = 8'h2F;
            4'd4: seg = 8'h66;
            4'd5: seg = 8'h6B;
            4'd6: seg = 8'h7B;
            4'd7: seg = 8'h0E;
            4'd8: seg = 8'h7F;
            4'd9: seg = 8'h6F;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

    // Exact for any 13-bit value: the reciprocal error stays below one step.
    function automatic logic [9:0] div10(input logic [12:0] x);
        logic [28:0] p;
        p = 29'(x) * 29'd52429;
        return p[28:19];
    endfunction

    // Exact up to well beyond the saturated time of 5999 s.
    function automatic logic [6:0] div60(input logic [12:0] x);
        logic [28:0] p;
        p = 29'(x) * 29'd34953;
        return p[27:21];
    endfunction

endpackage

### rtl/lcd_speed_time_frame_encoder_core.sv
// Top level of the LCD speed and time frame encoder.
//
// One input item per display refresh yields one frame item of six LCD segment bytes and
// a minutes flag. The block takes one item per clock cycle while the downstream side keeps
// taking frames: an item sits in the input register, where the speed ramp state is updated
// and the digits are formed, and then waits in the result register, from which it is
// offered downstream. The input side is ready whenever the input register is empty or its
// item moves on in the same cycle, so throughput stays at one item per cycle as long as
// the downstream side keeps taking frames. The ramp state advances only when an item
// moves from the input register to the result register, so items update it strictly in
// order.
`include "lcd_speed_time_frame_encoder_core_assert.svh"

module lcd_speed_time_frame_encoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // From bit 0: running, edit_mode[1:0], user_speed[11:0], target_speed[11:0],
    // measured_speed[11:0], set_seconds[15:0], elapsed_seconds[15:0], time_hidden,
    // jog_mode, speed_blank, time_blank, icon_blank, zero pad[3:0].
    input  logic [79:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // From bit 0: hundreds_segments[7:0], tens_segments[7:0], ones_segments[7:0],
    // time_high_segments[7:0], time_low_upper[7:0], time_low_lower[7:0],
    // minutes_unit, zero pad[6:0].
    output logic [55:0] o_m_axis_tdata
);

    logic                r_in_valid;
    lstfe_pkg::t_in_item r_in;
    logic                r_out_valid;
    lstfe_pkg::t_out_item r_out;

    logic [1:0]  r_ramp_mode, n_ramp_mode;
    logic [12:0] r_ramp_last, n_ramp_last;
    logic [12:0] r_shown, n_shown;

    logic out_free, advance;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign advance         = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out};

    // Ramp and speed selection.
    logic [12:0] meas, rel, target;
    logic [1:0]  mode_a;
    logic [12:0] last_a;

    always_comb begin
        meas   = {1'b0, r_in.measured_speed};
        target = {1'b0, r_in.target_speed};
        rel    = (meas >= lstfe_pkg::REMAP_KNEE) ?
                 13'((meas << 1) - lstfe_pkg::REMAP_KNEE) : meas;

        mode_a = r_ramp_mode;
        last_a = r_ramp_last;
        if (r_ramp_mode == lstfe_pkg::RAMP_IDLE) begin
            if (target > rel) begin
                mode_a = lstfe_pkg::RAMP_RISE;
                last_a = 13'd0;
            end else if (target <= r_shown) begin
                mode_a = lstfe_pkg::RAMP_FALL;
                last_a = rel;
            end
        end

        n_ramp_mode = r_ramp_mode;
        n_ramp_last = r_ramp_last;
        n_shown     = r_shown;
        if (!r_in.running || r_in.edit_mode == lstfe_pkg::EDIT_SPEED) begin
            n_shown = {1'b0, r_in.user_speed};
        end else begin
            n_ramp_mode = mode_a;
            n_ramp_last = last_a;
            case (mode_a)
                lstfe_pkg::RAMP_RISE: begin
                    if (rel >= target) begin
                        n_ramp_mode = lstfe_pkg::RAMP_HOLD;
                    end else begin
                        n_ramp_last = (rel > last_a) ? rel : last_a;
                        n_shown     = n_ramp_last;
                    end
                end
                lstfe_pkg::RAMP_FALL: begin
                    if (rel <= target) begin
                        n_ramp_mode = lstfe_pkg::RAMP_HOLD;
                    end else begin
                        n_ramp_last = (rel < last_a) ? rel : last_a;
                        n_shown     = n_ramp_last;
                    end
                end
                lstfe_pkg::RAMP_HOLD: n_shown = target;
                default:              n_shown = r_shown;
            endcase
        end
    end

    // Speed digits of shown_speed / 10.
    logic [9:0] spd, spd_q, spd_h;
    logic [3:0] spd_ones, spd_tens, spd_hund;

    always_comb begin
        spd      = lstfe_pkg::div10(n_shown);
        spd_q    = lstfe_pkg::div10(spd[9:0] >> 0 == 10'd0 ? 13'd0 : {3'd0, spd});
        spd_h    = lstfe_pkg::div10(spd_q[9:0] == 10'd0 ? 13'd0 : {3'd0, spd_q});
        spd_ones = 4'(spd - 10'(spd_q * 10'd10));
        spd_tens = 4'(spd_q - 10'(spd_h * 10'd10));
        spd_hund = spd_h[3:0];
    end

    // Time digits: minutes from one minute up, else seconds.
    logic [15:0] t_raw;
    logic [12:0] t_sat;
    logic [6:0]  minutes;
    logic [6:0]  t_val;
    logic [9:0]  t_tens;
    logic [3:0]  t_ones;
    logic        unit, time_valid;

    always_comb begin
        if (!r_in.running || r_in.edit_mode == lstfe_pkg::EDIT_TIME) begin
            t_raw = r_in.set_seconds;
        end else begin
            t_raw = r_in.elapsed_seconds;
        end
        t_sat      = (t_raw > 16'(lstfe_pkg::TIME_MAX)) ? lstfe_pkg::TIME_MAX : t_raw[12:0];
        unit       = (t_sat >= 13'd60);
        minutes    = lstfe_pkg::div60(t_sat);
        t_val      = unit ? minutes : t_sat[6:0];
        t_tens     = lstfe_pkg::div10({6'd0, t_val});
        t_ones     = 4'(t_val - 7'(t_tens[6:0] * 7'd10));
        time_valid = (r_in.set_seconds != 16'd0) && !r_in.time_hidden;
    end

    // Segment bytes.
    lstfe_pkg::t_out_item n_out;
    logic [7:0] seg_hi, seg_lo;

    always_comb begin
        seg_hi = 8'd0;
        seg_lo = 8'd0;
        if (!r_in.time_blank) begin
            seg_hi = time_valid ? lstfe_pkg::font(t_tens[3:0]) : lstfe_pkg::DASH_SEG;
            seg_lo = time_valid ? lstfe_pkg::font(t_ones) : lstfe_pkg::DASH_SEG;
        end
        n_out.hundreds_segments  = (!r_in.speed_blank && spd > 10'd99) ?
                                   lstfe_pkg::font(spd_hund) : 8'd0;
        n_out.tens_segments      = (!r_in.speed_blank && spd > 10'd9) ?
                                   lstfe_pkg::font(spd_tens) : 8'd0;
        n_out.ones_segments      = !r_in.speed_blank ? lstfe_pkg::font(spd_ones) : 8'd0;
        n_out.time_high_segments = {!r_in.icon_blank, seg_hi[6:0]};
        // Bit 3 is the min icon, bit 0 the sec icon, bits 2..1 the mode triangles.
        n_out.time_low_upper     = {seg_lo[7:4],
                                    !r_in.icon_blank && time_valid && unit,
                                    1'b1,
                                    !r_in.jog_mode,
                                    !r_in.icon_blank && time_valid && !unit};
        n_out.time_low_lower     = {seg_lo[3:0], 4'd0};
        n_out.minutes_unit       = unit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ramp_mode <= lstfe_pkg::RAMP_IDLE;
            r_ramp_last <= 13'd0;
            r_shown     <= 13'd0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_ramp_mode <= n_ramp_mode;
                r_ramp_last <= n_ramp_last;
                r_shown     <= n_shown;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in <= lstfe_pkg::t_in_item'(i_s_axis_tdata[75:0]);
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    `LSTFE_ASSERT_NEXT(a_hold_sticks, i_clk, i_rst_n,
        r_ramp_mode == lstfe_pkg::RAMP_HOLD, r_ramp_mode == lstfe_pkg::RAMP_HOLD)
    `LSTFE_ASSERT_NEXT(a_ramp_never_idles, i_clk, i_rst_n,
        r_ramp_mode != lstfe_pkg::RAMP_IDLE, r_ramp_mode != lstfe_pkg::RAMP_IDLE)
    `LSTFE_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n,
        !o_s_axis_tready, r_in_valid && r_out_valid && !i_m_axis_tready)
    `LSTFE_ASSERT_NEXT(a_state_moves_with_item, i_clk, i_rst_n,
        !advance, $stable(r_shown) && $stable(r_ramp_last))

endmodule

### test/tb_lcd_speed_time_frame_encoder_core.sv
// Self-checking testbench for the LCD speed and time frame encoder.
`timescale 1ns / 1ps

module tb_lcd_speed_time_frame_encoder_core;

    typedef struct packed {
        lstfe_pkg::t_in_item  tick;
        logic                 known;
        lstfe_pkg::t_out_item frame;
    } t_dir_row;

    // Flag bits in the order they sit above elapsed_seconds in an input item.
    localparam logic [4:0] F_HIDDEN = 5'b00001;
    localparam logic [4:0] F_JOG    = 5'b00010;
    localparam logic [4:0] F_SBLANK = 5'b00100;
    localparam logic [4:0] F_TBLANK = 5'b01000;
    localparam logic [4:0] F_IBLANK = 5'b10000;

    localparam logic [7:0] SEG_FONT [10] = '{8'h5F, 8'h06, 8'h3D, 8'h2F, 8'h66,
                                             8'h6B, 8'h7B, 8'h0E, 8'h7F, 8'h6F};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [79:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [55:0] o_m_axis_tdata;

    lcd_speed_time_frame_encoder_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    logic [1:0]  ramp_state = lstfe_pkg::RAMP_IDLE;
    logic [12:0] ramp_mark  = '0;
    logic [12:0] disp_speed = '0;

    lstfe_pkg::t_out_item frame_queue[$];
    t_dir_row             directed_rows[$];
    int                   mismatches      = 0;
    int                   feed_gap_pct    = 10;
    int                   drain_stall_pct = 10;
    lstfe_pkg::t_out_item rx_frame;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("lcd_speed_time_frame_encoder_core regression: fail");
        $finish;
    end

    function automatic lstfe_pkg::t_in_item make_tick(input logic run, input logic [1:0] edit,
                                           input logic [11:0] sspd, input logic [11:0] tspd,
                                           input logic [11:0] mspd, input logic [15:0] ssec,
                                           input logic [15:0] esec, input logic [4:0] flags);
        lstfe_pkg::t_in_item t;
        t = {flags, esec, ssec, mspd, tspd, sspd, edit, run};
        return t;
    endfunction

    function automatic lstfe_pkg::t_out_item make_frame(input logic [7:0] h,
                                             input logic [7:0] t,
                                             input logic [7:0] o, input logic [7:0] th,
                                             input logic [7:0] tu, input logic [7:0] tl,
                                             input logic unit);
        lstfe_pkg::t_out_item f;
        f = {unit, tl, tu, th, o, t, h};
        return f;
    endfunction

    function automatic logic [15:0] rand_seconds();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 130));
            1:       return 16'($urandom_range(5900, 6100));
            2:       return 16'($urandom_range(0, 6100));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic lstfe_pkg::t_in_item rand_tick();
        logic [4:0] flags;
        for (int b = 0; b < 5; b++) flags[b] = ($urandom_range(0, 3) == 0);
        return make_tick(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                         12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                         12'($urandom_range(0, 4095)), rand_seconds(),
                         rand_seconds(), flags);
    endfunction

    // Moves the shown speed toward the target from the remapped measured speed.
    function automatic void advance_ramp(input logic [11:0] target, input logic [11:0] measured);
        logic [12:0] rel;
        logic [12:0] tgt;
        tgt = {1'b0, target};
        if ({1'b0, measured} >= lstfe_pkg::REMAP_KNEE)
            rel = ({1'b0, measured} << 1) - lstfe_pkg::REMAP_KNEE;
        else rel = {1'b0, measured};

        if (ramp_state == lstfe_pkg::RAMP_IDLE) begin
            if (tgt > rel) begin
                ramp_mark  = '0;
                ramp_state = lstfe_pkg::RAMP_RISE;
            end else if (tgt <= disp_speed) begin
                ramp_mark  = rel;
                ramp_state = lstfe_pkg::RAMP_FALL;
            end
        end
        // Reaching the target only switches to holding; the shown speed waits a tick.
        case (ramp_state)
            lstfe_pkg::RAMP_RISE: begin
                if (rel >= tgt) ramp_state = lstfe_pkg::RAMP_HOLD;
                else begin
                    if (rel > ramp_mark) ramp_mark = rel;
                    disp_speed = ramp_mark;
                end
            end
            lstfe_pkg::RAMP_FALL: begin
                if (rel <= tgt) ramp_state = lstfe_pkg::RAMP_HOLD;
                else begin
                    if (rel < ramp_mark) ramp_mark = rel;
                    disp_speed = ramp_mark;
                end
            end
            lstfe_pkg::RAMP_HOLD: disp_speed = tgt;
            default: ;
        endcase
    endfunction

    function automatic lstfe_pkg::t_out_item render_frame(input lstfe_pkg::t_in_item it);
        lstfe_pkg::t_out_item f;
        int         tsec;
        int         spd;
        int         hi;
        int         lo;
        logic [7:0] hi_seg;
        logic [7:0] lo_seg;
        logic       valid;
        logic       icon_on;
        valid = (it.set_seconds != 0) && !it.time_hidden;
        if (!it.running) begin
            disp_speed = {1'b0, it.user_speed};
            tsec = it.set_seconds;
        end else if (it.edit_mode == lstfe_pkg::EDIT_SPEED) begin
            disp_speed = {1'b0, it.user_speed};
            tsec = it.elapsed_seconds;
        end else if (it.edit_mode == lstfe_pkg::EDIT_TIME) begin
            advance_ramp(it.target_speed, it.measured_speed);
            tsec = it.set_seconds;
        end else begin
            advance_ramp(it.target_speed, it.measured_speed);
            tsec = it.elapsed_seconds;
        end

        f = '0;
        spd = disp_speed / 10;
        if (!it.speed_blank) begin
            if (spd > 99) f.hundreds_segments = SEG_FONT[(spd / 100) % 10];
            if (spd > 9) f.tens_segments = SEG_FONT[(spd / 10) % 10];
            f.ones_segments = SEG_FONT[spd % 10];
        end

        if (tsec > int'(lstfe_pkg::TIME_MAX)) tsec = lstfe_pkg::TIME_MAX;
        f.minutes_unit = (tsec >= 60);
        if (f.minutes_unit) begin
            hi = (tsec / 60) / 10;
            lo = (tsec / 60) % 10;
        end else begin
            hi = (tsec % 60) / 10;
            lo = tsec % 10;
        end

        hi_seg = '0;
        lo_seg = '0;
        if (!it.time_blank) begin
            hi_seg = valid ? SEG_FONT[hi] : lstfe_pkg::DASH_SEG;
            lo_seg = valid ? SEG_FONT[lo] : lstfe_pkg::DASH_SEG;
        end
        hi_seg[7] = !it.icon_blank;
        icon_on = !it.icon_blank && valid;

        f.time_high_segments = hi_seg;
        f.time_low_upper = {lo_seg[7:4], icon_on && f.minutes_unit,
                            it.jog_mode ? 2'b10 : 2'b11, icon_on && !f.minutes_unit};
        f.time_low_lower = {lo_seg[3:0], 4'b0000};
        return f;
    endfunction

    task automatic offer_tick(input lstfe_pkg::t_in_item it, input logic known,
                              input lstfe_pkg::t_out_item typed);
        lstfe_pkg::t_out_item f;
        if ($urandom_range(0, 99) < feed_gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        i_s_axis_tdata  <= {4'b0000, it};
        i_s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        f = render_frame(it);
        frame_queue.push_back(known ? typed : f);
        @(negedge i_clk);
    endtask

    function automatic logic frame_differs(input lstfe_pkg::t_out_item a,
                                           input lstfe_pkg::t_out_item b);
        return (a.hundreds_segments !== b.hundreds_segments) ||
               (a.tens_segments !== b.tens_segments) ||
               (a.ones_segments !== b.ones_segments) ||
               (a.time_high_segments !== b.time_high_segments) ||
               (a.time_low_upper !== b.time_low_upper) ||
               (a.time_low_lower !== b.time_low_lower) ||
               (a.minutes_unit !== b.minutes_unit);
    endfunction

    task automatic flag_frame(input string what, input lstfe_pkg::t_out_item want,
                              input lstfe_pkg::t_out_item got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected %h %h %h %h %h %h %b, got %h %h %h %h %h %h %b",
                     $realtime, what,
                     want.hundreds_segments, want.tens_segments, want.ones_segments,
                     want.time_high_segments, want.time_low_upper, want.time_low_lower,
                     want.minutes_unit,
                     got.hundreds_segments, got.tens_segments, got.ones_segments,
                     got.time_high_segments, got.time_low_upper, got.time_low_lower,
                     got.minutes_unit);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            rx_frame = lstfe_pkg::t_out_item'(o_m_axis_tdata[48:0]);
            if (frame_queue.size() == 0) flag_frame("frame with none pending", '0, rx_frame);
            else if (frame_differs(frame_queue[0], rx_frame)) begin
                flag_frame("frame mismatch", frame_queue[0], rx_frame);
                void'(frame_queue.pop_front());
            end else void'(frame_queue.pop_front());
        end
    end

    initial begin
        i_m_axis_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 99) < drain_stall_pct) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        lstfe_pkg::t_in_item it;
        int       meas;
        int       k;
        int       n;
        int       wait_cycles;
        logic     rising;
        logic [11:0] tgt;
        logic [11:0] start_speed;

        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;

        directed_rows.push_back('{make_tick(0, lstfe_pkg::EDIT_NONE, 0, 0, 0, 0, 0, 5'b0),
            1'b1, make_frame(8'h00, 8'h00, 8'h5F, 8'hA0, 8'h26, 8'h00, 1'b0)});
        directed_rows.push_back('{make_tick(0, lstfe_pkg::EDIT_NONE, 4095, 0, 0, 65535, 0,
            F_IBLANK | F_TBLANK | F_SBLANK | F_JOG), 1'b1,
            make_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h04, 8'h00, 1'b1)});
        directed_rows.push_back('{make_tick(0, lstfe_pkg::EDIT_NONE, 4095, 4095, 4095, 65535,
            65535, 5'b0), 1'b1, make_frame(8'h66, 8'h5F, 8'h6F, 8'hEF, 8'h6E, 8'hF0, 1'b1)});
        directed_rows.push_back('{make_tick(0, lstfe_pkg::EDIT_NONE, 99, 0, 0, 59, 0, 5'b0),
            1'b0, '0});
        directed_rows.push_back('{make_tick(0, lstfe_pkg::EDIT_NONE, 100, 0, 0, 60, 0, F_JOG),
            1'b0, '0});
        directed_rows.push_back('{make_tick(0, lstfe_pkg::EDIT_TIME, 999, 0, 0, 1, 0,
            F_HIDDEN), 1'b0, '0});
        directed_rows.push_back('{make_tick(0, lstfe_pkg::EDIT_SPARE, 1000, 0, 0, 0, 0,
            F_TBLANK), 1'b0, '0});
        directed_rows.push_back('{make_tick(1, lstfe_pkg::EDIT_SPEED, 1234, 0, 0, 5, 6000,
            5'b0), 1'b0, '0});
        directed_rows.push_back('{make_tick(1, lstfe_pkg::EDIT_SPEED, 50, 0, 0, 65535, 0,
            F_IBLANK), 1'b0, '0});
        // The next three leave the ramp waiting: target between shown and remapped speed.
        directed_rows.push_back('{make_tick(1, lstfe_pkg::EDIT_NONE, 0, 500, 600, 10, 3599,
            5'b0), 1'b0, '0});
        directed_rows.push_back('{make_tick(1, lstfe_pkg::EDIT_TIME, 0, 2000, 2300, 119, 0,
            F_JOG), 1'b0, '0});
        directed_rows.push_back('{make_tick(1, lstfe_pkg::EDIT_SPARE, 0, 4095, 4095, 300, 61,
            5'b0), 1'b0, '0});
        directed_rows.push_back('{make_tick(0, lstfe_pkg::EDIT_NONE, 2199, 0, 2199, 3599, 0,
            F_JOG | F_IBLANK), 1'b0, '0});
        directed_rows.push_back('{make_tick(0, lstfe_pkg::EDIT_SPARE, 9, 0, 0, 65535, 65535,
            F_HIDDEN | F_SBLANK), 1'b0, '0});
        directed_rows.push_back('{make_tick(1, lstfe_pkg::EDIT_SPEED, 4095, 4095, 0, 5999,
            6000, F_TBLANK | F_IBLANK), 1'b0, '0});
        directed_rows.push_back('{make_tick(1, lstfe_pkg::EDIT_SPEED, 10, 0, 0, 5940, 59,
            F_HIDDEN | F_IBLANK), 1'b0, '0});

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r])
            offer_tick(directed_rows[r].tick, directed_rows[r].known, directed_rows[r].frame);

        // One ramp per run, since only reset leaves holding: pick the direction at random.
        rising = 1'($urandom_range(0, 1));
        if (rising) begin
            tgt  = 12'($urandom_range(300, 4095));
            meas = $urandom_range(0, (tgt <= 12'd2200) ? tgt - 1 : 2199);
        end else begin
            start_speed = 12'($urandom_range(2000, 4095));
            it = rand_tick();
            it.running    = 1'b0;
            it.user_speed = start_speed;
            offer_tick(it, 1'b0, '0);
            tgt  = 12'($urandom_range(0, start_speed));
            meas = $urandom_range(3500, 4095);
        end
        n = 0;
        while (ramp_state != lstfe_pkg::RAMP_HOLD && n < 600) begin
            it = rand_tick();
            if (ramp_state != lstfe_pkg::RAMP_IDLE && $urandom_range(0, 99) < 15) begin
                if ($urandom_range(0, 1)) it.running = 1'b0;
                else begin
                    it.running   = 1'b1;
                    it.edit_mode = lstfe_pkg::EDIT_SPEED;
                end
            end else begin
                k = $urandom_range(0, 2);
                it.running        = 1'b1;
                it.edit_mode      = (k == 0) ? lstfe_pkg::EDIT_NONE :
                                    (k == 1) ? lstfe_pkg::EDIT_TIME : lstfe_pkg::EDIT_SPARE;
                it.target_speed   = tgt;
                it.measured_speed = 12'(meas);
                // Mostly toward the target, with the odd step back.
                k = ($urandom_range(0, 9) == 0) ? -$urandom_range(0, 40) : $urandom_range(0, 80);
                meas = rising ? meas + k : meas - k;
                if (meas < 0) meas = 0;
                if (meas > 4095) meas = 4095;
            end
            offer_tick(it, 1'b0, '0);
            n++;
        end

        for (int i = 0; i < 1250; i++) begin
            if (i % 200 == 0) begin
                k = $urandom_range(0, 2);
                feed_gap_pct = (k == 0) ? 0 : (k == 1) ? 10 : 35;
                k = $urandom_range(0, 2);
                drain_stall_pct = (k == 0) ? 0 : (k == 1) ? 5 : 20;
            end
            if (i >= 1100) begin
                feed_gap_pct    = 0;
                drain_stall_pct = 0;
            end
            offer_tick(rand_tick(), 1'b0, '0);
        end
        i_s_axis_tvalid <= 1'b0;

        wait_cycles = 0;
        while (frame_queue.size() != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && frame_queue.size() == 0)
            $display("lcd_speed_time_frame_encoder_core regression: pass");
        else
            $display("lcd_speed_time_frame_encoder_core regression: fail");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/lstfe_pkg.sv
rtl/lcd_speed_time_frame_encoder_core.sv
test/tb_lcd_speed_time_frame_encoder_core.sv
